// File: rtl/dmr_pkg.sv
package dmr_pkg;

   localparam int RING_DEPTH  = 64;
   localparam int MAX_RESULTS = 64;
   localparam int IDX_W       = $clog2(RING_DEPTH);
   localparam int OCC_W       = IDX_W + 1;
   localparam int CNT_W       = 7;
   localparam int CMP_W       = (OCC_W > CNT_W) ? OCC_W : CNT_W;
   localparam int CSR_IDX_W   = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_SYNCED_UPTIME  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REFERENCE_UNIX = 1'b1;

   typedef enum logic [1:0] {
      CMD_STORE   = 2'd0,
      CMD_READ    = 2'd1,
      CMD_RELEASE = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_STORE   = 2'd0,
      KIND_RECORD  = 2'd1,
      KIND_EMPTY   = 2'd2,
      KIND_RELEASE = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_COMPACT,
      ST_COMPACT_END,
      ST_STORE,
      ST_RELEASE,
      ST_READ_ISSUE,
      ST_READ_EMIT,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic [31:0] uptime;
      logic [15:0] battery;
      logic [15:0] moisture;
      logic [15:0] temperature;
   } record_type;

   typedef struct packed {
      logic load_req;
      logic clear_index;
      logic compact_step;
      logic compact_finish;
      logic store_write;
      logic release_apply;
      logic read_issue;
      logic emit_record;
      logic emit_reply;
   } ctrl_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    ring_full;
      logic    read_none;
      logic    compact_last;
      logic    read_last;
      logic    out_free;
   } ctrl_status_type;

endpackage

// File: rtl/decimating_measurement_ring.sv
// Decimating measurement ring: a ring of sensor records with store, read and
// release commands.
// Request channel (req_*): one beat carries a command and its fields; the
// beat is taken when req_valid is high and req_stall is low. Commands are
// handled one at a time; req_stall stays high until the current command has
// loaded its last result into the output register.
// Result channel (rsp_*): one registered output beat, taken when rsp_valid
// is high and rsp_stall is low. A stalled beat holds; the block finishes its
// work up to the next result and waits there. A new request is taken while
// the final result of the previous one still waits.
// Configuration (csr_*): csr_ready is always high; index 0 is the synced
// uptime, index 1 the matching Unix time. Write only while idle.
// Steps per command: store is dispatch, write, reply; a store into a full
// ring compacts first, one record moved per cycle through the record memory
// (each read while the one before is written); release is dispatch, apply,
// reply; read is dispatch, then memory read and output load per record, or
// a reply if it finds nothing. An unused command code gives no result.
// Reset clears the ring to empty, the interval multiplier to one and both
// configuration registers to zero; the record memory is not cleared.
module decimating_measurement_ring (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_cmd,
   input  logic [31:0]                   req_uptime_s,
   input  logic [15:0]                   req_battery_value,
   input  logic [15:0]                   req_moisture_value,
   input  logic signed [15:0]            req_temperature_value,
   input  logic [dmr_pkg::CNT_W-1:0]     req_count,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [dmr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_kind,
   output logic [31:0]                   rsp_unix_time_s,
   output logic [15:0]                   rsp_out_battery,
   output logic signed [15:0]            rsp_out_temperature,
   output logic [15:0]                   rsp_out_moisture,
   output logic                          rsp_last,
   output logic                          rsp_records_remain,
   output logic                          rsp_was_compacted,
   output logic [31:0]                   rsp_interval_multiplier
);

   dmr_pkg::ctrl_cmd_type    ctrl_cmd;
   dmr_pkg::ctrl_status_type ctrl_status;

   assign csr_ready = 1'b1;

   dmr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (ctrl_status),
      .cmd       (ctrl_cmd)
   );

   dmr_datapath u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (ctrl_cmd),
      .status                  (ctrl_status),
      .req_cmd                 (req_cmd),
      .req_uptime_s            (req_uptime_s),
      .req_battery_value       (req_battery_value),
      .req_moisture_value      (req_moisture_value),
      .req_temperature_value   (req_temperature_value),
      .req_count               (req_count),
      .csr_valid               (csr_valid & csr_ready),
      .csr_index               (csr_index),
      .csr_data                (csr_data),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_kind                (rsp_kind),
      .rsp_unix_time_s         (rsp_unix_time_s),
      .rsp_out_battery         (rsp_out_battery),
      .rsp_out_temperature     (rsp_out_temperature),
      .rsp_out_moisture        (rsp_out_moisture),
      .rsp_last                (rsp_last),
      .rsp_records_remain      (rsp_records_remain),
      .rsp_was_compacted       (rsp_was_compacted),
      .rsp_interval_multiplier (rsp_interval_multiplier)
   );

endmodule

// File: rtl/dmr_ctrl.sv
module dmr_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  dmr_pkg::ctrl_status_type status,
   output dmr_pkg::ctrl_cmd_type    cmd
);

   dmr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dmr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dmr_pkg::ST_IDLE: begin
            if (req_valid) state_in = dmr_pkg::ST_DISPATCH;
         end
         dmr_pkg::ST_DISPATCH: begin
            unique case (status.cmd)
               dmr_pkg::CMD_STORE:
                  state_in = status.ring_full ? dmr_pkg::ST_COMPACT : dmr_pkg::ST_STORE;
               dmr_pkg::CMD_READ:
                  state_in = status.read_none ? dmr_pkg::ST_REPLY : dmr_pkg::ST_READ_ISSUE;
               dmr_pkg::CMD_RELEASE:
                  state_in = dmr_pkg::ST_RELEASE;
               default:
                  state_in = dmr_pkg::ST_IDLE;
            endcase
         end
         dmr_pkg::ST_COMPACT: begin
            if (status.compact_last) state_in = dmr_pkg::ST_COMPACT_END;
         end
         dmr_pkg::ST_COMPACT_END: state_in = dmr_pkg::ST_STORE;
         dmr_pkg::ST_STORE:       state_in = dmr_pkg::ST_REPLY;
         dmr_pkg::ST_RELEASE:     state_in = dmr_pkg::ST_REPLY;
         dmr_pkg::ST_READ_ISSUE:  state_in = dmr_pkg::ST_READ_EMIT;
         dmr_pkg::ST_READ_EMIT: begin
            if (status.out_free) begin
               state_in = status.read_last ? dmr_pkg::ST_IDLE : dmr_pkg::ST_READ_ISSUE;
            end
         end
         dmr_pkg::ST_REPLY: begin
            if (status.out_free) state_in = dmr_pkg::ST_IDLE;
         end
         default: state_in = dmr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         dmr_pkg::ST_IDLE: begin
            req_stall    = 1'b0;
            cmd.load_req = req_valid;
         end
         dmr_pkg::ST_DISPATCH:    cmd.clear_index    = 1'b1;
         dmr_pkg::ST_COMPACT:     cmd.compact_step   = 1'b1;
         dmr_pkg::ST_COMPACT_END: cmd.compact_finish = 1'b1;
         dmr_pkg::ST_STORE:       cmd.store_write    = 1'b1;
         dmr_pkg::ST_RELEASE:     cmd.release_apply  = 1'b1;
         dmr_pkg::ST_READ_ISSUE:  cmd.read_issue     = 1'b1;
         dmr_pkg::ST_READ_EMIT:   cmd.emit_record    = status.out_free;
         dmr_pkg::ST_REPLY:       cmd.emit_reply     = status.out_free;
         default: ;
      endcase
   end

endmodule

// File: rtl/dmr_datapath.sv
module dmr_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  dmr_pkg::ctrl_cmd_type             cmd,
   output dmr_pkg::ctrl_status_type          status,
   input  logic [1:0]                        req_cmd,
   input  logic [31:0]                       req_uptime_s,
   input  logic [15:0]                       req_battery_value,
   input  logic [15:0]                       req_moisture_value,
   input  logic signed [15:0]                req_temperature_value,
   input  logic [dmr_pkg::CNT_W-1:0]         req_count,
   input  logic                              csr_valid,
   input  logic [dmr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                       csr_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_kind,
   output logic [31:0]                       rsp_unix_time_s,
   output logic [15:0]                       rsp_out_battery,
   output logic signed [15:0]                rsp_out_temperature,
   output logic [15:0]                       rsp_out_moisture,
   output logic                              rsp_last,
   output logic                              rsp_records_remain,
   output logic                              rsp_was_compacted,
   output logic [31:0]                       rsp_interval_multiplier
);

   localparam int IdxW  = dmr_pkg::IDX_W;
   localparam int OccW  = dmr_pkg::OCC_W;
   localparam int CmpW  = dmr_pkg::CMP_W;
   localparam int Depth = dmr_pkg::RING_DEPTH;

   // configuration
   logic [31:0] synced_ff, reference_ff;

   // ring control state
   logic [IdxW-1:0] oldest_ff, write_ff, idx_ff;
   logic [OccW-1:0] occ_ff;
   logic [31:0]     mult_ff;
   logic            comp_ff;

   // latched request
   dmr_pkg::cmd_type          cmd_ff;
   dmr_pkg::record_type       rec_ff;
   logic [dmr_pkg::CNT_W-1:0] count_ff;

   // record memory
   dmr_pkg::record_type mem [Depth];
   dmr_pkg::record_type rd_data_ff;
   logic                cp_wr_ff;
   logic [IdxW-1:0]     cp_dst_ff;
   logic [IdxW-1:0]     rd_addr;

   // result register
   logic                rsp_valid_ff;
   dmr_pkg::kind_type   kind_ff;
   logic [31:0]         time_ff;
   dmr_pkg::record_type out_rec_ff;
   logic                last_ff, remain_ff, was_comp_ff;
   logic [31:0]         out_mult_ff;

   logic [CmpW-1:0] count_w, occ_w, rel_n, rd_n, idx_next_w;
   logic            out_free;

   assign count_w    = CmpW'(count_ff);
   assign occ_w      = CmpW'(occ_ff);
   assign rel_n      = (count_w > occ_w) ? occ_w : count_w;
   assign rd_n       = (rel_n > CmpW'(dmr_pkg::MAX_RESULTS)) ?
                       CmpW'(dmr_pkg::MAX_RESULTS) : rel_n;
   assign idx_next_w = CmpW'(idx_ff) + CmpW'(1);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign status.cmd          = cmd_ff;
   assign status.ring_full    = (occ_ff == OccW'(Depth));
   assign status.read_none    = (rd_n == '0);
   assign status.compact_last = (idx_ff == IdxW'(Depth / 2 - 1));
   assign status.read_last    = (idx_next_w == rd_n);
   assign status.out_free     = out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         synced_ff    <= '0;
         reference_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            dmr_pkg::CSR_SYNCED_UPTIME:  synced_ff    <= csr_data;
            dmr_pkg::CSR_REFERENCE_UNIX: reference_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // latch the request beat
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cmd_ff              <= dmr_pkg::cmd_type'(req_cmd);
         count_ff            <= req_count;
         rec_ff.uptime       <= req_uptime_s;
         rec_ff.battery      <= req_battery_value;
         rec_ff.moisture     <= req_moisture_value;
         rec_ff.temperature  <= req_temperature_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff <= '0;
         write_ff  <= '0;
         occ_ff    <= '0;
         mult_ff   <= 32'd1;
         comp_ff   <= 1'b0;
         idx_ff    <= '0;
      end else begin
         if (cmd.load_req) comp_ff <= 1'b0;
         if (cmd.clear_index) begin
            idx_ff <= '0;
         end else if (cmd.compact_step || cmd.emit_record) begin
            idx_ff <= idx_ff + IdxW'(1);
         end
         if (cmd.compact_finish) begin
            occ_ff   <= OccW'(Depth / 2);
            write_ff <= oldest_ff + IdxW'(Depth / 2);
            mult_ff  <= {mult_ff[30:0], 1'b0};
            comp_ff  <= 1'b1;
         end
         if (cmd.store_write) begin
            write_ff <= write_ff + IdxW'(1);
            occ_ff   <= occ_ff + OccW'(1);
         end
         if (cmd.release_apply) begin
            oldest_ff <= oldest_ff + IdxW'(rel_n);
            occ_ff    <= occ_ff - OccW'(rel_n);
         end
      end
   end

   // compaction reads slot oldest+2i and writes it to oldest+i in the next cycle
   always_comb begin
      if (cmd.compact_step) begin
         rd_addr = oldest_ff + {idx_ff[IdxW-2:0], 1'b0};
      end else begin
         rd_addr = oldest_ff + idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cp_wr_ff <= 1'b0;
      end else begin
         cp_wr_ff <= cmd.compact_step;
      end
   end

   always_ff @(posedge clock) begin
      cp_dst_ff <= oldest_ff + idx_ff;
      if (cmd.compact_step || cmd.read_issue) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (cp_wr_ff) begin
         mem[cp_dst_ff] <= rd_data_ff;
      end else if (cmd.store_write) begin
         mem[write_ff] <= rec_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_record || cmd.emit_reply) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_record) begin
         kind_ff     <= dmr_pkg::KIND_RECORD;
         time_ff     <= rd_data_ff.uptime - synced_ff + reference_ff;
         out_rec_ff  <= rd_data_ff;
         last_ff     <= status.read_last;
         remain_ff   <= (occ_ff != '0);
         was_comp_ff <= 1'b0;
         out_mult_ff <= mult_ff;
      end else if (cmd.emit_reply) begin
         case (cmd_ff)
            dmr_pkg::CMD_STORE:   kind_ff <= dmr_pkg::KIND_STORE;
            dmr_pkg::CMD_RELEASE: kind_ff <= dmr_pkg::KIND_RELEASE;
            default:              kind_ff <= dmr_pkg::KIND_EMPTY;
         endcase
         time_ff     <= '0;
         out_rec_ff  <= '0;
         last_ff     <= 1'b1;
         remain_ff   <= (occ_ff != '0);
         was_comp_ff <= (cmd_ff == dmr_pkg::CMD_STORE) && comp_ff;
         out_mult_ff <= mult_ff;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_kind                = kind_ff;
   assign rsp_unix_time_s         = time_ff;
   assign rsp_out_battery         = out_rec_ff.battery;
   assign rsp_out_temperature     = $signed(out_rec_ff.temperature);
   assign rsp_out_moisture        = out_rec_ff.moisture;
   assign rsp_last                = last_ff;
   assign rsp_records_remain      = remain_ff;
   assign rsp_was_compacted       = was_comp_ff;
   assign rsp_interval_multiplier = out_mult_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OccW'(Depth))
      else $error("occupancy beyond ring depth");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(cp_wr_ff && cmd.store_write))
      else $error("compaction write collides with store write");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_record || cmd.emit_reply) |-> out_free)
      else $error("result loaded over a pending beat");

   a_compact_half: assert property (@(posedge clock) disable iff (reset)
      cmd.compact_finish |=> (occ_ff == OccW'(Depth / 2)) && comp_ff)
      else $error("compaction did not halve the ring");

endmodule

// File: tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int SETTLE_CYCLES = dmr_pkg::RING_DEPTH / 2 + 8;
   localparam int PRINT_LIMIT   = 200;
   localparam int IdxW          = dmr_pkg::IDX_W;
   localparam int CntW          = dmr_pkg::CNT_W;

   typedef struct {
      dmr_pkg::cmd_type  cmd;
      logic [31:0]       uptime;
      logic [15:0]       battery;
      logic [15:0]       moisture;
      logic [15:0]       temperature;
      logic [CntW-1:0]   count;
   } request_type;

   typedef struct {
      dmr_pkg::kind_type kind;
      logic [31:0]       unix_time;
      logic [15:0]       battery;
      logic [15:0]       temperature;
      logic [15:0]       moisture;
      logic              last;
      logic              remain;
      logic              compacted;
      logic [31:0]       multiplier;
   } response_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [1:0]                     req_cmd = '0;
   logic [31:0]                    req_uptime_s = '0;
   logic [15:0]                    req_battery_value = '0;
   logic [15:0]                    req_moisture_value = '0;
   logic signed [15:0]             req_temperature_value = '0;
   logic [CntW-1:0]                req_count = '0;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [dmr_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [31:0]                    csr_data = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [1:0]                     rsp_kind;
   logic [31:0]                    rsp_unix_time_s;
   logic [15:0]                    rsp_out_battery;
   logic signed [15:0]             rsp_out_temperature;
   logic [15:0]                    rsp_out_moisture;
   logic                           rsp_last;
   logic                           rsp_records_remain;
   logic                           rsp_was_compacted;
   logic [31:0]                    rsp_interval_multiplier;

   // ring predictor state
   logic [31:0]     ring_time        [dmr_pkg::RING_DEPTH];
   logic [15:0]     ring_battery     [dmr_pkg::RING_DEPTH];
   logic [15:0]     ring_moisture    [dmr_pkg::RING_DEPTH];
   logic [15:0]     ring_temperature [dmr_pkg::RING_DEPTH];
   logic [IdxW-1:0] head_index    = '0;
   logic [IdxW-1:0] tail_index    = '0;
   int unsigned     fill_level    = 0;
   logic [31:0]     interval_mult = 32'd1;
   logic [31:0]     cfg_synced    = '0;
   logic [31:0]     cfg_reference = '0;

   response_type pending_responses[$];
   int           error_count  = 0;
   int           cycle_count  = 0;
   bit           gaps_on      = 1'b1;
   bit           stalls_on    = 1'b1;
   int           hold_request = 0;

   decimating_measurement_ring u_top (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_cmd                 (req_cmd),
      .req_uptime_s            (req_uptime_s),
      .req_battery_value       (req_battery_value),
      .req_moisture_value      (req_moisture_value),
      .req_temperature_value   (req_temperature_value),
      .req_count               (req_count),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_data                (csr_data),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_kind                (rsp_kind),
      .rsp_unix_time_s         (rsp_unix_time_s),
      .rsp_out_battery         (rsp_out_battery),
      .rsp_out_temperature     (rsp_out_temperature),
      .rsp_out_moisture        (rsp_out_moisture),
      .rsp_last                (rsp_last),
      .rsp_records_remain      (rsp_records_remain),
      .rsp_was_compacted       (rsp_was_compacted),
      .rsp_interval_multiplier (rsp_interval_multiplier)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   function automatic void push_response(dmr_pkg::kind_type kind, logic [31:0] unix_time,
                                         logic [15:0] battery, logic [15:0] temperature,
                                         logic [15:0] moisture, logic last,
                                         logic compacted);
      response_type r;
      r.kind        = kind;
      r.unix_time   = unix_time;
      r.battery     = battery;
      r.temperature = temperature;
      r.moisture    = moisture;
      r.last        = last;
      r.remain      = (fill_level != 0);
      r.compacted   = compacted;
      r.multiplier  = interval_mult;
      pending_responses.push_back(r);
   endfunction

   function automatic void apply_command(request_type r);
      int unsigned     n;
      logic [IdxW-1:0] idx;
      logic [IdxW-1:0] src;
      logic [IdxW-1:0] dst;
      logic            compacted;
      logic [31:0]     stamp;
      case (r.cmd)
         dmr_pkg::CMD_STORE: begin
            compacted = 1'b0;
            if (fill_level >= dmr_pkg::RING_DEPTH) begin
               // keep every second record from the oldest, in place
               for (int i = 0; i < dmr_pkg::RING_DEPTH / 2; i++) begin
                  dst = head_index + IdxW'(i);
                  src = head_index + IdxW'(2 * i);
                  ring_time[dst]        = ring_time[src];
                  ring_battery[dst]     = ring_battery[src];
                  ring_moisture[dst]    = ring_moisture[src];
                  ring_temperature[dst] = ring_temperature[src];
               end
               fill_level    = dmr_pkg::RING_DEPTH / 2;
               tail_index    = head_index + IdxW'(dmr_pkg::RING_DEPTH / 2);
               interval_mult = interval_mult << 1;
               compacted     = 1'b1;
            end
            ring_time[tail_index]        = r.uptime;
            ring_battery[tail_index]     = r.battery;
            ring_moisture[tail_index]    = r.moisture;
            ring_temperature[tail_index] = r.temperature;
            tail_index = tail_index + IdxW'(1);
            fill_level++;
            push_response(dmr_pkg::KIND_STORE, '0, '0, '0, '0, 1'b1, compacted);
         end
         dmr_pkg::CMD_READ: begin
            n = 32'(r.count);
            if (n > fill_level) n = fill_level;
            if (n > dmr_pkg::MAX_RESULTS) n = dmr_pkg::MAX_RESULTS;
            if (n == 0) begin
               push_response(dmr_pkg::KIND_EMPTY, '0, '0, '0, '0, 1'b1, 1'b0);
            end else begin
               for (int i = 0; i < n; i++) begin
                  idx   = head_index + IdxW'(i);
                  stamp = ring_time[idx] - cfg_synced + cfg_reference;
                  push_response(dmr_pkg::KIND_RECORD, stamp, ring_battery[idx],
                                ring_temperature[idx], ring_moisture[idx], (i + 1 == n),
                                1'b0);
               end
            end
         end
         dmr_pkg::CMD_RELEASE: begin
            n = 32'(r.count);
            if (n > fill_level) n = fill_level;
            head_index = head_index + IdxW'(n);
            fill_level = fill_level - n;
            push_response(dmr_pkg::KIND_RELEASE, '0, '0, '0, '0, 1'b1, 1'b0);
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("%0t ns: mismatch: %s", $time, msg);
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   // result checker
   initial begin
      response_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_responses.size() == 0) begin
               report_mismatch("result beat with nothing expected");
            end else begin
               want = pending_responses.pop_front();
               compare_field("kind", 32'(rsp_kind), 32'(want.kind));
               compare_field("unix_time_s", rsp_unix_time_s, want.unix_time);
               compare_field("out_battery", 32'(rsp_out_battery), 32'(want.battery));
               compare_field("out_temperature", 32'($unsigned(rsp_out_temperature)),
                             32'(want.temperature));
               compare_field("out_moisture", 32'(rsp_out_moisture), 32'(want.moisture));
               compare_field("last", 32'(rsp_last), 32'(want.last));
               compare_field("records_remain", 32'(rsp_records_remain), 32'(want.remain));
               compare_field("was_compacted", 32'(rsp_was_compacted), 32'(want.compacted));
               compare_field("interval_multiplier", rsp_interval_multiplier,
                             want.multiplier);
            end
         end
      end
   end

   // result stall: random runs, plus long hold-offs on request
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (!stalls_on || $urandom_range(0, 99) < 65) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall  <= 1'b1;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20)
                                                     : $urandom_range(0, 2);
         end
      end
   end

   function automatic int pick_gap();
      int roll;
      if (!gaps_on) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [31:0] pick_word();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 20) return 32'h0000_0000;
      if (roll < 40) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   function automatic request_type make_request(dmr_pkg::cmd_type cmd, logic [31:0] uptime,
                                                logic [15:0] battery, logic [15:0] moisture,
                                                logic [15:0] temperature,
                                                logic [CntW-1:0] count);
      request_type r;
      r.cmd         = cmd;
      r.uptime      = uptime;
      r.battery     = battery;
      r.moisture    = moisture;
      r.temperature = temperature;
      r.count       = count;
      return r;
   endfunction

   function automatic request_type random_request();
      request_type r;
      int          roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)      r.cmd = dmr_pkg::CMD_STORE;
      else if (roll < 78) r.cmd = dmr_pkg::CMD_READ;
      else if (roll < 95) r.cmd = dmr_pkg::CMD_RELEASE;
      else                r.cmd = dmr_pkg::CMD_NONE;
      r.uptime      = $urandom;
      r.battery     = 16'($urandom);
      r.moisture    = 16'($urandom);
      r.temperature = 16'($urandom);
      r.count       = CntW'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 8)
                                   : $urandom_range(0, dmr_pkg::MAX_RESULTS));
      return r;
   endfunction

   // keep valid high across back-to-back beats; drop it only for a gap
   task automatic send_request(input request_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_cmd               <= r.cmd;
      req_uptime_s          <= r.uptime;
      req_battery_value     <= r.battery;
      req_moisture_value    <= r.moisture;
      req_temperature_value <= r.temperature;
      req_count             <= r.count;
      req_valid             <= 1'b1;
      do @(posedge clock); while (req_stall);
      apply_command(r);
   endtask

   task automatic drain_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [dmr_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == dmr_pkg::CSR_SYNCED_UPTIME) cfg_synced = value;
      else cfg_reference = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_empty_ring();
      send_request(make_request(dmr_pkg::CMD_READ, '0, '0, '0, '0, CntW'(0)));
      send_request(make_request(dmr_pkg::CMD_READ, '1, '1, '1, '1,
                                CntW'(dmr_pkg::MAX_RESULTS)));
      send_request(make_request(dmr_pkg::CMD_RELEASE, '0, '0, '0, '0, CntW'(0)));
      send_request(make_request(dmr_pkg::CMD_RELEASE, '0, '0, '0, '0,
                                CntW'(dmr_pkg::MAX_RESULTS)));
      // unused code: no beat back, no state change
      send_request(make_request(dmr_pkg::CMD_NONE, '1, '1, '1, '1, '1));
      drain_responses();
   endtask

   task automatic test_record_fields();
      write_register(dmr_pkg::CSR_SYNCED_UPTIME, 32'h0000_1000);
      write_register(dmr_pkg::CSR_REFERENCE_UNIX, 32'h6000_0000);
      send_request(make_request(dmr_pkg::CMD_STORE, 32'h0000_0000, 16'h0000, 16'hFFFF,
                                16'h8000, '0));
      send_request(make_request(dmr_pkg::CMD_STORE, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000,
                                16'h7FFF, '0));
      send_request(make_request(dmr_pkg::CMD_STORE, 32'hAAAA_AAAA, 16'h5555, 16'hAAAA,
                                16'hFFFF, '0));
      send_request(make_request(dmr_pkg::CMD_STORE, 32'h5555_5555, 16'hAAAA, 16'h5555,
                                16'h0000, '0));
      send_request(make_request(dmr_pkg::CMD_READ, '0, '0, '0, '0, CntW'(2)));
      send_request(make_request(dmr_pkg::CMD_READ, '0, '0, '0, '0,
                                CntW'(dmr_pkg::MAX_RESULTS)));
      send_request(make_request(dmr_pkg::CMD_RELEASE, '0, '0, '0, '0, CntW'(0)));
      send_request(make_request(dmr_pkg::CMD_RELEASE, '0, '0, '0, '0, CntW'(1)));
      send_request(make_request(dmr_pkg::CMD_READ, '0, '0, '0, '0, CntW'(1)));
      send_request(make_request(dmr_pkg::CMD_RELEASE, '0, '0, '0, '0,
                                CntW'(dmr_pkg::MAX_RESULTS)));
      send_request(make_request(dmr_pkg::CMD_READ, '0, '0, '0, '0, CntW'(5)));
      send_request(make_request(dmr_pkg::CMD_STORE, 32'h0000_1000, 16'h1234, 16'h4321,
                                16'hF00D, '0));
      drain_responses();
      write_register(dmr_pkg::CSR_SYNCED_UPTIME, 32'hFFFF_FFFF);
      write_register(dmr_pkg::CSR_REFERENCE_UNIX, 32'h0000_0000);
      send_request(make_request(dmr_pkg::CMD_READ, '0, '0, '0, '0, CntW'(1)));
      drain_responses();
      write_register(dmr_pkg::CSR_SYNCED_UPTIME, 32'h0000_0000);
      write_register(dmr_pkg::CSR_REFERENCE_UNIX, 32'hFFFF_FFFF);
      send_request(make_request(dmr_pkg::CMD_READ, '0, '0, '0, '0, CntW'(1)));
      send_request(make_request(dmr_pkg::CMD_RELEASE, '0, '0, '0, '0, CntW'(1)));
      drain_responses();
   endtask

   task automatic test_output_backpressure();
      request_type r;
      gaps_on      = 1'b0;
      hold_request = 250;
      for (int i = 0; i < 16; i++) begin
         r = random_request();
         r.cmd = (i % 4 == 3) ? dmr_pkg::CMD_READ : dmr_pkg::CMD_STORE;
         send_request(r);
      end
      send_request(make_request(dmr_pkg::CMD_READ, '0, '0, '0, '0,
                                CntW'(dmr_pkg::MAX_RESULTS)));
      send_request(make_request(dmr_pkg::CMD_RELEASE, '0, '0, '0, '0, CntW'(3)));
      drain_responses();
      gaps_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      request_type r;
      int          sent;
      for (int phase = 0; phase < 4; phase++) begin
         write_register(dmr_pkg::CSR_SYNCED_UPTIME, pick_word());
         write_register(dmr_pkg::CSR_REFERENCE_UNIX, pick_word());
         gaps_on   = (phase == 0) || (phase == 2);
         stalls_on = (phase == 0) || (phase == 3);
         sent = 0;
         while (sent < 55) begin
            r = random_request();
            send_request(r);
            if (r.cmd != dmr_pkg::CMD_NONE) sent++;
         end
         drain_responses();
      end
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
   endtask

   task automatic test_repeated_compaction();
      request_type r;
      // enough stores to overflow the ring from any fill level
      repeat (80) begin
         r = random_request();
         r.cmd = dmr_pkg::CMD_STORE;
         send_request(r);
      end
      send_request(make_request(dmr_pkg::CMD_READ, '0, '0, '0, '0,
                                CntW'(dmr_pkg::MAX_RESULTS)));
      send_request(make_request(dmr_pkg::CMD_RELEASE, '0, '0, '0, '0,
                                CntW'(dmr_pkg::MAX_RESULTS)));
      drain_responses();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_ring();
      test_record_fields();
      test_output_backpressure();
      test_random_traffic();
      test_repeated_compaction();
      drain_responses();
      if (pending_responses.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_responses.size()));
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
